// File: design/gbn_pkg.sv
package gbn_pkg;

	localparam int MaxBoxes  = 64;
	localparam int CoordBits = 16;
	localparam int IdxBits   = $clog2(MaxBoxes);
	localparam int CntBits   = IdxBits + 1;
	localparam int AreaBits  = 2 * CoordBits;
	localparam int EdgeBits  = CoordBits + 1;

	localparam logic [16:0] HalfQ16 = 17'd32768;
	localparam logic [16:0] OneQ16  = 17'd65536;

	localparam logic [1:0] REG_SCORE_THR   = 2'd0;
	localparam logic [1:0] REG_OVERLAP_THR = 2'd1;
	localparam logic [1:0] REG_DECAY       = 2'd2;
	localparam logic [1:0] REG_TOP_COUNT   = 2'd3;

	typedef struct packed {
		logic [15:0] box_x;
		logic [15:0] box_y;
		logic [15:0] box_width;
		logic [15:0] box_height;
		logic [15:0] score;
		logic        last_box;
	} box_in_t;

	typedef struct packed {
		logic [5:0] kept_index;
		logic       last_kept;
		logic       none_kept;
	} kept_out_t;

	typedef struct packed {
		logic [CoordBits-1:0] x;
		logic [CoordBits-1:0] y;
		logic [CoordBits-1:0] w;
		logic [CoordBits-1:0] h;
	} geom_t;

	// Request to the overlap unit and its answer.
	typedef struct packed {
		logic start;
		logic [16:0] thr;
	} iou_req_t;

	typedef struct packed {
		logic done;
		logic exceeds;
	} iou_rsp_t;

endpackage

// File: design/gbn_iou.sv
// Multi-cycle overlap test. One 33x17 multiplier is shared: it forms the
// areas, the intersection, then the threshold times union product.
module gbn_iou (
	input  logic              clk,
	input  logic              arst_n,
	input  gbn_pkg::iou_req_t req,
	input  gbn_pkg::geom_t    a,
	input  gbn_pkg::geom_t    b,
	output gbn_pkg::iou_rsp_t rsp
);

	typedef enum logic [2:0] {S_IDLE, S_EDGE, S_AREA_A, S_AREA_B, S_INTER, S_RHS, S_CMP}
		state_t;

	state_t state_q;
	logic [gbn_pkg::EdgeBits-1:0] iw_q, ih_q;
	logic [gbn_pkg::AreaBits-1:0] area_a_q, area_b_q, inter_q;
	logic [gbn_pkg::AreaBits:0]   uni_q;
	logic [gbn_pkg::AreaBits+17:0] rhs_q;
	logic                         zero_q;

	logic [gbn_pkg::AreaBits:0]   mul_a;
	logic [16:0]                  mul_b;
	logic [gbn_pkg::AreaBits+17:0] mul_p;

	logic [gbn_pkg::EdgeBits-1:0] x1, y1, x2, y2, ax2, bx2, ay2, by2;
	logic [gbn_pkg::AreaBits:0]   sum_ab;

	always_comb begin
		ax2 = {1'b0, a.x} + {1'b0, a.w};
		bx2 = {1'b0, b.x} + {1'b0, b.w};
		ay2 = {1'b0, a.y} + {1'b0, a.h};
		by2 = {1'b0, b.y} + {1'b0, b.h};
		x1 = (a.x > b.x) ? {1'b0, a.x} : {1'b0, b.x};
		y1 = (a.y > b.y) ? {1'b0, a.y} : {1'b0, b.y};
		x2 = (ax2 < bx2) ? ax2 : bx2;
		y2 = (ay2 < by2) ? ay2 : by2;
		sum_ab = {1'b0, area_a_q} + {1'b0, area_b_q};
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_AREA_A: begin
				mul_a = {{(gbn_pkg::AreaBits+1-gbn_pkg::CoordBits){1'b0}}, a.w};
				mul_b = {{(17-gbn_pkg::CoordBits){1'b0}}, a.h};
			end
			S_AREA_B: begin
				mul_a = {{(gbn_pkg::AreaBits+1-gbn_pkg::CoordBits){1'b0}}, b.w};
				mul_b = {{(17-gbn_pkg::CoordBits){1'b0}}, b.h};
			end
			S_INTER: begin
				mul_a = {{(gbn_pkg::AreaBits+1-gbn_pkg::EdgeBits){1'b0}}, iw_q};
				mul_b = {{(17-gbn_pkg::EdgeBits){1'b0}}, ih_q};
			end
			S_RHS: begin
				mul_a = uni_q;
				mul_b = req.thr;
			end
			default: ;
		endcase
		mul_p = {17'd0, mul_a} * {{(gbn_pkg::AreaBits+1){1'b0}}, mul_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp <= '0;
		end else begin
			rsp.done <= (state_q == S_CMP);
			case (state_q)
				S_IDLE: if (req.start) state_q <= S_EDGE;
				S_EDGE: begin
					iw_q <= (x2 > x1) ? x2 - x1 : '0;
					ih_q <= (y2 > y1) ? y2 - y1 : '0;
					state_q <= S_AREA_A;
				end
				S_AREA_A: begin
					area_a_q <= mul_p[gbn_pkg::AreaBits-1:0];
					state_q <= S_AREA_B;
				end
				S_AREA_B: begin
					area_b_q <= mul_p[gbn_pkg::AreaBits-1:0];
					state_q <= S_INTER;
				end
				S_INTER: begin
					inter_q <= mul_p[gbn_pkg::AreaBits-1:0];
					uni_q <= sum_ab - {1'b0, mul_p[gbn_pkg::AreaBits-1:0]};
					zero_q <= (sum_ab == '0);
					state_q <= S_RHS;
				end
				S_RHS: begin
					rhs_q <= mul_p;
					state_q <= S_CMP;
				end
				S_CMP: begin
					rsp.exceeds <= zero_q ? (req.thr < gbn_pkg::OneQ16)
						: ({2'b0, inter_q, 16'd0} > rhs_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(state_q == S_CMP))
		else $error("overlap answer without compare step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.start) |=> state_q == S_EDGE)
		else $error("overlap unit missed a start");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INTER |=> (uni_q <= {1'b0, area_a_q} + {1'b0, area_b_q}))
		else $error("union above sum of areas");

endmodule

// File: design/greedy_box_nms.sv
// Greedy non-maximum suppression. Boxes are loaded one per start beat, one
// cycle each, and may follow back to back. The beat whose last_box is set
// begins a run, during which busy is high and no box is taken. First the
// candidates scoring above the score limit are insertion-sorted into rank
// order: each box is looked at, moved up one place at a time past lower
// scores and then placed. The list is cut to the top count if one is set.
// Then each candidate is tested by the shared overlap unit against the boxes
// kept so far, in turn, until one overlaps it too much. The kept indices then
// come out on result with result_valid high for exactly one cycle each; the
// receiver cannot hold them off, so it must take every beat. busy drops in
// the cycle that shows the final result. A run that keeps nothing gives a
// single beat with none_kept set. Configuration writes are taken at any time
// but should only be made while the block is idle.
module greedy_box_nms (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gbn_pkg::box_in_t    box_in,
	output logic                result_valid,
	output gbn_pkg::kept_out_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [16:0]         cfg_data
);

	localparam int IB = gbn_pkg::IdxBits;
	localparam int CB = gbn_pkg::CntBits;

	typedef enum logic [3:0] {
		S_LOAD, S_SCAN, S_SHIFT_RD, S_SHIFT, S_PLACE, S_TRIM, S_CAND, S_CAND_RD,
		S_PAIR, S_PAIR_WAIT, S_KEEP, S_EMIT, S_EMIT_RD
	} state_t;

	state_t state_q;

	logic [15:0] score_thr_q;
	logic [16:0] overlap_thr_q, decay_q, cur_thr_q;
	logic [6:0]  top_count_q;

	// Stores, each written at one address and read at one address a cycle.
	gbn_pkg::geom_t box_mem [gbn_pkg::MaxBoxes];
	logic [15:0]    score_mem [gbn_pkg::MaxBoxes];
	logic [IB-1:0]  rank_mem [gbn_pkg::MaxBoxes];
	logic [IB-1:0]  kept_mem [gbn_pkg::MaxBoxes];

	logic [CB-1:0] box_count_q, cand_count_q, kept_count_q, i_q, pos_q, k_q;
	logic [IB-1:0] rank_rd_q, kept_rd_q;
	logic [15:0]   score_rd_q, cur_score_q;
	gbn_pkg::geom_t geom_a_q, geom_b_q;
	logic           keep_q;

	logic [IB-1:0] score_addr, box_addr, rank_addr, kept_addr;
	logic          rank_we, kept_we;
	logic [IB-1:0] rank_wa, rank_wd;

	gbn_pkg::iou_req_t iou_req;
	gbn_pkg::iou_rsp_t iou_rsp;
	logic [33:0]       decay_prod;
	logic              load_beat;

	assign load_beat = start && !busy;
	assign busy = (state_q != S_LOAD);
	assign cfg_ready = 1'b1;
	assign decay_prod = {17'd0, cur_thr_q} * {17'd0, decay_q} + 34'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q   <= '0;
			overlap_thr_q <= gbn_pkg::HalfQ16;
			decay_q       <= gbn_pkg::OneQ16;
			top_count_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gbn_pkg::REG_SCORE_THR:   score_thr_q <= cfg_data[15:0];
				gbn_pkg::REG_OVERLAP_THR: overlap_thr_q <= cfg_data;
				gbn_pkg::REG_DECAY:       decay_q <= cfg_data;
				gbn_pkg::REG_TOP_COUNT:   top_count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Read addresses for the registered memory reads. The rank entry above
	// the insertion point is read first and then its score, before its compare,
	// so the scan and shift states already address the entry the next compare needs.
	// While candidates are tested the rank read stays on the current one.
	always_comb begin
		score_addr = i_q[IB-1:0];
		rank_addr  = pos_q[IB-1:0] - 1'b1;
		box_addr   = rank_rd_q;
		kept_addr  = k_q[IB-1:0];
		rank_we    = 1'b0;
		rank_wa    = pos_q[IB-1:0];
		rank_wd    = rank_rd_q;
		kept_we    = 1'b0;
		case (state_q)
			S_SCAN: rank_addr = cand_count_q[IB-1:0] - 1'b1;
			S_SHIFT_RD: score_addr = rank_rd_q;
			S_SHIFT: begin
				rank_we = (score_rd_q < cur_score_q);
				rank_addr = pos_q[IB-1:0] - 2'd2;
			end
			S_PLACE: begin
				rank_we = 1'b1;
				rank_wd = i_q[IB-1:0];
			end
			S_CAND: rank_addr = i_q[IB-1:0];
			S_CAND_RD: rank_addr = i_q[IB-1:0];
			S_PAIR: begin
				box_addr = kept_rd_q;
				rank_addr = i_q[IB-1:0];
			end
			S_PAIR_WAIT: rank_addr = i_q[IB-1:0];
			S_KEEP: begin
				kept_we = keep_q;
				rank_addr = i_q[IB-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_beat && box_count_q < CB'(gbn_pkg::MaxBoxes)) begin
			box_mem[box_count_q[IB-1:0]] <= '{box_in.box_x, box_in.box_y,
				box_in.box_width, box_in.box_height};
			score_mem[box_count_q[IB-1:0]] <= box_in.score;
		end
		if (rank_we) rank_mem[rank_wa] <= rank_wd;
		if (kept_we) kept_mem[kept_count_q[IB-1:0]] <= rank_rd_q;
		score_rd_q <= score_mem[score_addr];
		rank_rd_q  <= rank_mem[rank_addr];
		kept_rd_q  <= kept_mem[kept_addr];
		if (state_q == S_CAND_RD) geom_a_q <= box_mem[box_addr];
		if (state_q == S_PAIR)    geom_b_q <= box_mem[box_addr];
	end

	gbn_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iou_req),
		.a      (geom_a_q),
		.b      (geom_b_q),
		.rsp    (iou_rsp)
	);

	// Sequencer. The registered reads are timed by dedicated read states.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			box_count_q  <= '0;
			cand_count_q <= '0;
			kept_count_q <= '0;
			cur_thr_q    <= '0;
			i_q          <= '0;
			pos_q        <= '0;
			k_q          <= '0;
			keep_q       <= 1'b0;
			iou_req      <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			result_valid <= (state_q == S_EMIT_RD);
			iou_req.start <= (state_q == S_PAIR);
			iou_req.thr <= cur_thr_q;
			case (state_q)
				S_LOAD: if (load_beat) begin
					if (box_count_q < CB'(gbn_pkg::MaxBoxes))
						box_count_q <= box_count_q + 1'b1;
					if (box_in.last_box) begin
						i_q <= '0;
						cand_count_q <= '0;
						state_q <= S_SCAN;
					end
				end
				// score_rd_q holds the score of box i_q in the following state.
				S_SCAN: begin
					pos_q <= cand_count_q;
					if (i_q == box_count_q) state_q <= S_TRIM;
					else state_q <= S_SHIFT_RD;
				end
				S_SHIFT_RD: begin
					if (pos_q == cand_count_q) cur_score_q <= score_rd_q;
					if (pos_q == cand_count_q && score_rd_q <= score_thr_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_SCAN;
					end else if (pos_q == '0) state_q <= S_PLACE;
					else state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					// score_rd_q is the score of rank_mem[pos-1].
					if (score_rd_q < cur_score_q) begin
						pos_q <= pos_q - 1'b1;
						if (pos_q == CB'(1)) state_q <= S_PLACE;
						else state_q <= S_SHIFT_RD;
					end else state_q <= S_PLACE;
				end
				S_PLACE: begin
					cand_count_q <= cand_count_q + 1'b1;
					i_q <= i_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_TRIM: begin
					if (top_count_q != '0 && top_count_q < cand_count_q)
						cand_count_q <= top_count_q;
					cur_thr_q <= overlap_thr_q;
					kept_count_q <= '0;
					i_q <= '0;
					state_q <= S_CAND;
				end
				S_CAND: begin
					k_q <= '0;
					keep_q <= 1'b1;
					if (i_q == cand_count_q) state_q <= S_EMIT;
					else state_q <= S_CAND_RD;
				end
				S_CAND_RD: begin
					if (kept_count_q == '0) state_q <= S_KEEP;
					else state_q <= S_PAIR;
				end
				S_PAIR: state_q <= S_PAIR_WAIT;
				S_PAIR_WAIT: if (iou_rsp.done) begin
					if (iou_rsp.exceeds) begin
						keep_q <= 1'b0;
						state_q <= S_KEEP;
					end else if (k_q + 1'b1 == kept_count_q) state_q <= S_KEEP;
					else begin
						k_q <= k_q + 1'b1;
						state_q <= S_CAND_RD;
					end
				end
				S_KEEP: begin
					if (keep_q) begin
						kept_count_q <= kept_count_q + 1'b1;
						if (decay_q < gbn_pkg::OneQ16 && cur_thr_q > gbn_pkg::HalfQ16)
							cur_thr_q <= decay_prod[32:16];
					end
					i_q <= i_q + 1'b1;
					state_q <= S_CAND;
				end
				S_EMIT: state_q <= S_EMIT_RD;
				S_EMIT_RD: begin
					if (kept_count_q == '0) begin
						result <= '{6'd0, 1'b1, 1'b1};
						box_count_q <= '0;
						state_q <= S_LOAD;
					end else begin
						result <= '{6'(kept_rd_q), (k_q + 1'b1 == kept_count_q), 1'b0};
						k_q <= k_q + 1'b1;
						if (k_q + 1'b1 == kept_count_q) begin
							box_count_q <= '0;
							state_q <= S_LOAD;
						end else state_q <= S_EMIT;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy || $past(busy))
		else $error("result outside a run");
	assert property (@(posedge clk) disable iff (!arst_n)
		box_count_q <= CB'(gbn_pkg::MaxBoxes))
		else $error("box count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CAND |-> kept_count_q <= i_q && i_q <= cand_count_q)
		else $error("more kept than candidates");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

// Bench for the greedy box suppression block. Boxes go in as command beats
// (start with busy low), and the beat carrying last_box sets off a run. The
// bench keeps its own copy of the box store and the four registers. On every
// last box it ranks and suppresses the set exactly as the block should, and
// queues the kept indices. The checker takes each result beat as it comes and
// compares it with the oldest queued index.
module tb;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	gbn_pkg::box_in_t   box_in;
	logic               result_valid;
	gbn_pkg::kept_out_t result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [16:0]        cfg_data;

	greedy_box_nms uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .box_in(box_in),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Our own view of the registers and of the boxes loaded so far.
	logic [15:0]      min_score;
	logic [16:0]      start_overlap;
	logic [16:0]      decay;
	logic [6:0]       keep_limit;
	gbn_pkg::box_in_t loaded[gbn_pkg::MaxBoxes];
	int               loaded_count;

	gbn_pkg::kept_out_t kept_q[$];
	int          errors;
	int          mismatches;
	int          runs_done;
	int          results_seen;
	int          boxes_sent;
	int          idle_cycles;
	bit          no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// True when box a overlaps box b by more than the threshold allows.
	// Both sides of the IoU comparison are formed exactly in 64 bits.
	function automatic bit overlap_too_big(gbn_pkg::box_in_t a, gbn_pkg::box_in_t b,
		logic [16:0] thr);
		longint unsigned area_a, area_b, x1, y1, x2, y2, inter, uni;
		area_a = 64'(a.box_width) * 64'(a.box_height);
		area_b = 64'(b.box_width) * 64'(b.box_height);
		if (area_a + area_b == 0)
			return thr < gbn_pkg::OneQ16;
		x1 = (a.box_x > b.box_x) ? a.box_x : b.box_x;
		y1 = (a.box_y > b.box_y) ? a.box_y : b.box_y;
		x2 = ((64'(a.box_x) + a.box_width) < (64'(b.box_x) + b.box_width)) ?
			64'(a.box_x) + a.box_width : 64'(b.box_x) + b.box_width;
		y2 = ((64'(a.box_y) + a.box_height) < (64'(b.box_y) + b.box_height)) ?
			64'(a.box_y) + a.box_height : 64'(b.box_y) + b.box_height;
		inter = (x2 > x1 && y2 > y1) ? (x2 - x1) * (y2 - y1) : 0;
		uni = area_a + area_b - inter;
		return (inter << 16) > (64'(thr) * uni);
	endfunction

	// Ranks the loaded set, suppresses it and queues the indices it keeps.
	task automatic suppress_set();
		int ranked[gbn_pkg::MaxBoxes];
		int kept[gbn_pkg::MaxBoxes];
		int n_cand, n_kept, pos;
		logic [16:0] thr;
		bit keep;
		gbn_pkg::kept_out_t r;
		n_cand = 0;
		for (int i = 0; i < loaded_count; i++) begin
			if (loaded[i].score > min_score) begin
				// Stable insertion, so equal scores keep their load order.
				pos = n_cand;
				while (pos > 0 && loaded[ranked[pos-1]].score < loaded[i].score) begin
					ranked[pos] = ranked[pos-1];
					pos--;
				end
				ranked[pos] = i;
				n_cand++;
			end
		end
		if (keep_limit != 0 && keep_limit < n_cand)
			n_cand = keep_limit;
		thr = start_overlap;
		n_kept = 0;
		for (int i = 0; i < n_cand; i++) begin
			keep = 1'b1;
			for (int k = 0; k < n_kept && keep; k++)
				keep = !overlap_too_big(loaded[ranked[i]], loaded[kept[k]], thr);
			if (keep) begin
				kept[n_kept++] = ranked[i];
				if (decay < gbn_pkg::OneQ16 && thr > gbn_pkg::HalfQ16)
					thr = 17'((64'(thr) * decay + gbn_pkg::HalfQ16) >> 16);
			end
		end
		if (n_kept == 0) begin
			r.kept_index = '0;
			r.last_kept  = 1'b1;
			r.none_kept  = 1'b1;
			kept_q = {kept_q, r};
		end else begin
			for (int k = 0; k < n_kept; k++) begin
				r.kept_index = 6'(kept[k]);
				r.last_kept  = (k == n_kept - 1);
				r.none_kept  = 1'b0;
				kept_q = {kept_q, r};
			end
		end
		loaded_count = 0;
		runs_done++;
	endtask

	// Sends one box beat. start is left high after the beat so that the next
	// box can follow at once; after the last box of a set it is dropped.
	task automatic send_box(gbn_pkg::box_in_t b);
		int gap;
		if (!no_gaps && $urandom_range(0, 99) < 5) begin
			gap = $urandom_range(1, 2);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start  <= 1'b1;
		box_in <= b;
		do @(posedge clk); while (busy);
		boxes_sent++;
		// A full store drops the box, but a last box still starts the run.
		if (loaded_count < gbn_pkg::MaxBoxes)
			loaded[loaded_count++] = b;
		if (b.last_box) begin
			suppress_set();
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Waits for every queued result and then lets the block settle.
	task automatic wait_drained();
		do @(posedge clk); while (kept_q.size() != 0 || busy);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			gbn_pkg::REG_SCORE_THR:   min_score     = value[15:0];
			gbn_pkg::REG_OVERLAP_THR: start_overlap = value;
			gbn_pkg::REG_DECAY:       decay         = value;
			gbn_pkg::REG_TOP_COUNT:   keep_limit    = value[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(logic [15:0] s, logic [16:0] o, logic [16:0] d, logic [6:0] t);
		wait_drained();
		write_reg(gbn_pkg::REG_SCORE_THR, {1'b0, s});
		write_reg(gbn_pkg::REG_OVERLAP_THR, o);
		write_reg(gbn_pkg::REG_DECAY, d);
		write_reg(gbn_pkg::REG_TOP_COUNT, {10'd0, t});
	endtask

	function automatic gbn_pkg::box_in_t make_box(int x, int y, int w, int h, int s,
		bit last);
		gbn_pkg::box_in_t b;
		b.box_x = 16'(x);
		b.box_y = 16'(y);
		b.box_width = 16'(w);
		b.box_height = 16'(h);
		b.score = 16'(s);
		b.last_box = last;
		return b;
	endfunction

	// A box jittered around a cluster centre, so that overlaps are common.
	function automatic gbn_pkg::box_in_t near_box(int cx, int cy, bit last);
		return make_box(cx + $urandom_range(0, 24), cy + $urandom_range(0, 24),
			$urandom_range(8, 60), $urandom_range(8, 60),
			$urandom_range(0, 7) == 0 ? 16'h0400 : $urandom, last);
	endfunction

	function automatic gbn_pkg::box_in_t noise_box(bit last);
		return make_box($urandom, $urandom, $urandom, $urandom, $urandom, last);
	endfunction

	// Extremes of every field and the corner cases of the overlap test.
	task automatic test_directed();
		set_regs(16'd0, 17'd32768, 17'd65536, 7'd0);
		// A single box on its own.
		send_box(make_box(10, 10, 20, 20, 300, 1'b1));
		// Boxes at the ends of the coordinate range, two of them with full sizes.
		send_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		send_box(make_box(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
		send_box(make_box(16'hFFFF, 0, 1, 16'hFFFF, 1, 1'b1));
		// Two zero-area boxes: overlap counts as one, so the second goes.
		send_box(make_box(5, 5, 0, 0, 500, 1'b0));
		send_box(make_box(900, 900, 0, 0, 400, 1'b1));
		// Identical boxes with tied scores: load order decides.
		send_box(make_box(40, 40, 30, 30, 256, 1'b0));
		send_box(make_box(40, 40, 30, 30, 256, 1'b0));
		send_box(make_box(200, 40, 30, 30, 256, 1'b1));
		// Scores at or under the threshold give the none-kept beat.
		set_regs(16'd1000, 17'd65536, 17'd0, 7'd1);
		send_box(make_box(1, 2, 3, 4, 1000, 1'b0));
		send_box(make_box(1, 2, 3, 4, 0, 1'b1));
		// Threshold of one and zero areas; with a top count of one only the best box is kept.
		send_box(make_box(7, 7, 0, 9, 1001, 1'b0));
		send_box(make_box(7, 7, 9, 0, 2000, 1'b1));
		set_regs(16'hFFFF, 17'd0, 17'd0, 7'd64);
		send_box(make_box(3, 3, 3, 3, 16'hFFFF, 1'b1));
	endtask

	// More boxes than the store holds: the extra ones are dropped.
	task automatic test_full_store();
		set_regs(16'd0, 17'd65536, 17'd65536, 7'd0);
		for (int i = 0; i < gbn_pkg::MaxBoxes + 2; i++)
			send_box(make_box(i * 100, i * 50, 60, 60, $urandom_range(1, 16'hFFFF),
				i == gbn_pkg::MaxBoxes + 1));
	endtask

	// Random sets under a sweep of settings; most boxes in a set are clustered
	// to exercise suppression and decay, the rest are noise.
	task automatic test_random();
		int n, cx, cy;
		logic [15:0] s;
		logic [16:0] o, d;
		logic [6:0]  t;
		for (int set = 0; set < 30; set++) begin
			if (set % 5 == 0) begin
				s = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 16'h2000));
				o = 17'($urandom_range(0, 65536));
				d = ($urandom_range(0, 3) == 0) ? 17'd65536 : 17'($urandom_range(0, 65536));
				t = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(1, 64));
				set_regs(s, o, d, t);
			end
			no_gaps = (set >= 10 && set < 15);
			n = $urandom_range(1, 9);
			cx = $urandom_range(0, 65000);
			cy = $urandom_range(0, 65000);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 99) < 15)
					send_box(noise_box(i == n - 1));
				else
					send_box(near_box(cx, cy, i == n - 1));
			end
			// Once, hold back until the block has handed over everything.
			if (set == 20)
				wait_drained();
		end
		no_gaps = 1'b0;
	endtask

	// Result checker: every beat must match the oldest queued index.
	always @(posedge clk) begin
		if (result_valid) begin
			results_seen++;
			if (kept_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected result beat %p", result);
			end else begin
				if (result !== kept_q[0]) begin
					errors++;
					if (mismatches++ < 10)
						$display("result mismatch: expected %p, got %p", kept_q[0], result);
				end
				void'(kept_q.pop_front());
			end
		end
	end

	// Watchdog: too long without any beat on any port ends the run.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 300000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		box_in = '0;
		cfg_valid = 1'b0;
		cfg_index = gbn_pkg::REG_SCORE_THR;
		cfg_data = '0;
		min_score = 16'd0;
		start_overlap = 17'd32768;
		decay = 17'd65536;
		keep_limit = 7'd0;
		loaded_count = 0;
		errors = 0;
		mismatches = 0;
		runs_done = 0;
		results_seen = 0;
		boxes_sent = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_store();
		test_random();
		wait_drained();

		$display("Covered %0d boxes in %0d suppression runs, %0d result beats checked.",
			boxes_sent, runs_done, results_seen);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
